// File: hw/rtl/bole_pkg.sv
// Shared types, field widths and codes for the bounded ordered list engine.
package bole_pkg;

    localparam int ACTION_W       = 3;
    localparam int VALUE_W        = 32;
    localparam int STATUS_W       = 2;
    localparam int LIST_DEPTH_DEF = 16;

    typedef logic        [ACTION_W-1:0] t_action;
    typedef logic signed [VALUE_W-1:0]  t_value;
    typedef logic        [STATUS_W-1:0] t_status;

    localparam t_action ACT_APPEND     = 3'd0;
    localparam t_action ACT_REM_HEAD   = 3'd1;
    localparam t_action ACT_REM_TAIL   = 3'd2;
    localparam t_action ACT_REM_AFTER  = 3'd3;
    localparam t_action ACT_REM_BEFORE = 3'd4;
    localparam t_action ACT_LIST       = 3'd5;

    localparam t_status ST_DONE     = 2'd0;
    localparam t_status ST_EMPTY    = 2'd1;
    localparam t_status ST_NOTFOUND = 2'd2;
    localparam t_status ST_FULL     = 2'd3;

endpackage

// File: hw/rtl/bole_if.sv
// Valid/ready channel interfaces for the command and result beats.
interface bole_in_if import bole_pkg::*;;
    logic    valid;
    logic    ready;
    t_action action;
    t_value  value;

    modport source (output valid, output action, output value, input ready);
    modport sink   (input valid, input action, input value, output ready);
endinterface

interface bole_out_if import bole_pkg::*;;
    logic    valid;
    logic    ready;
    t_status status;
    t_value  result_value;
    logic    last;

    modport source (output valid, output status, output result_value, output last, input ready);
    modport sink   (input valid, input status, input result_value, input last, output ready);
endinterface

// File: hw/rtl/bounded_ordered_list_engine_core.sv
// An append, or a command that finds the list empty, goes straight to S_EMIT for its result beat.
// A removal walks the store through one read port: a key search for removals after or before a
// key, a fetch of the victim, then the entries behind it closed up one place each, then S_EMIT.
// A listing gives one beat per stored entry after a registered read, one per cycle unless stalled.
// The engine takes no new command until the current one has loaded its last beat for output.
// Synchronous active-low reset empties the list; the entry store itself is not cleared.
module bounded_ordered_list_engine_core import bole_pkg::*; #(
    parameter int LIST_DEPTH = LIST_DEPTH_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    bole_in_if.sink    i_in,
    bole_out_if.source o_out
);

    localparam int AW = $clog2(LIST_DEPTH);
    localparam int CW = $clog2(LIST_DEPTH + 1);

    typedef logic [AW-1:0] t_addr;
    typedef logic [CW-1:0] t_cnt;

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_SEARCH = 3'd1;
    localparam logic [2:0] S_FETCH  = 3'd2;
    localparam logic [2:0] S_TAKE   = 3'd3;
    localparam logic [2:0] S_SHIFT  = 3'd4;
    localparam logic [2:0] S_LIST   = 3'd5;
    localparam logic [2:0] S_EMIT   = 3'd6;

    localparam t_cnt CNT_FULL = t_cnt'(LIST_DEPTH);

    logic [2:0] r_state, n_state;
    t_cnt       r_count, n_count;
    t_addr      r_ptr, n_ptr;
    t_action    r_action, n_action;
    t_value     r_key, n_key;
    t_status    r_pend_status, n_pend_status;
    t_value     r_pend_value, n_pend_value;
    logic       r_out_valid, n_out_valid;
    t_status    r_out_status, n_out_status;
    t_value     r_out_value, n_out_value;
    logic       r_out_last, n_out_last;

    logic   ram_wr_en;
    t_addr  ram_wr_addr;
    t_value ram_wr_data;
    logic   ram_rd_en;
    t_addr  ram_rd_addr;
    t_value rd_data;

    logic   slot_free;
    t_cnt   ptr_p1;
    t_cnt   cnt_m1;

    bole_ram #(
        .WIDTH (VALUE_W),
        .DEPTH (LIST_DEPTH)
    ) u_store (
        .i_clk     (i_clk),
        .i_wr_en   (ram_wr_en),
        .i_wr_addr (ram_wr_addr),
        .i_wr_data (ram_wr_data),
        .i_rd_en   (ram_rd_en),
        .i_rd_addr (ram_rd_addr),
        .o_rd_data (rd_data)
    );

    assign slot_free = !r_out_valid || o_out.ready;
    assign ptr_p1    = t_cnt'(r_ptr) + t_cnt'(1);
    assign cnt_m1    = r_count - t_cnt'(1);

    always_comb begin
        n_state       = r_state;
        n_count       = r_count;
        n_ptr         = r_ptr;
        n_action      = r_action;
        n_key         = r_key;
        n_pend_status = r_pend_status;
        n_pend_value  = r_pend_value;
        n_out_valid   = r_out_valid && !o_out.ready;
        n_out_status  = r_out_status;
        n_out_value   = r_out_value;
        n_out_last    = r_out_last;
        ram_wr_en     = 1'b0;
        ram_wr_addr   = r_ptr;
        ram_wr_data   = rd_data;
        ram_rd_en     = 1'b0;
        ram_rd_addr   = r_ptr;

        case (r_state)
            S_IDLE: begin
                if (i_in.valid) begin
                    n_action     = i_in.action;
                    n_key        = i_in.value;
                    n_pend_value = '0;
                    case (i_in.action)
                        ACT_APPEND: begin
                            n_state = S_EMIT;
                            if (r_count == CNT_FULL) begin
                                n_pend_status = ST_FULL;
                            end else begin
                                ram_wr_en     = 1'b1;
                                ram_wr_addr   = r_count[AW-1:0];
                                ram_wr_data   = i_in.value;
                                n_count       = r_count + t_cnt'(1);
                                n_pend_status = ST_DONE;
                            end
                        end
                        ACT_REM_HEAD, ACT_REM_TAIL: begin
                            if (r_count == '0) begin
                                n_pend_status = ST_EMPTY;
                                n_state       = S_EMIT;
                            end else begin
                                n_ptr   = (i_in.action == ACT_REM_HEAD) ? '0 : cnt_m1[AW-1:0];
                                n_state = S_FETCH;
                            end
                        end
                        ACT_REM_AFTER, ACT_REM_BEFORE: begin
                            if (r_count == '0) begin
                                n_pend_status = ST_NOTFOUND;
                                n_state       = S_EMIT;
                            end else begin
                                ram_rd_en   = 1'b1;
                                ram_rd_addr = '0;
                                n_ptr       = '0;
                                n_state     = S_SEARCH;
                            end
                        end
                        ACT_LIST: begin
                            if (r_count == '0) begin
                                n_pend_status = ST_EMPTY;
                                n_state       = S_EMIT;
                            end else begin
                                ram_rd_en   = 1'b1;
                                ram_rd_addr = '0;
                                n_ptr       = '0;
                                n_state     = S_LIST;
                            end
                        end
                        default: begin
                            // Undefined actions are dropped without a result beat.
                            n_state = S_IDLE;
                        end
                    endcase
                end
            end
            S_SEARCH: begin
                // The read data always belongs to the entry at r_ptr.
                if (rd_data == r_key) begin
                    if (r_action == ACT_REM_AFTER) begin
                        if (ptr_p1 < r_count) begin
                            n_ptr   = r_ptr + t_addr'(1);
                            n_state = S_FETCH;
                        end else begin
                            n_pend_status = ST_NOTFOUND;
                            n_state       = S_EMIT;
                        end
                    end else begin
                        if (r_ptr == '0) begin
                            n_pend_status = ST_NOTFOUND;
                            n_state       = S_EMIT;
                        end else begin
                            n_ptr   = r_ptr - t_addr'(1);
                            n_state = S_FETCH;
                        end
                    end
                end else if (ptr_p1 < r_count) begin
                    ram_rd_en   = 1'b1;
                    ram_rd_addr = r_ptr + t_addr'(1);
                    n_ptr       = r_ptr + t_addr'(1);
                end else begin
                    n_pend_status = ST_NOTFOUND;
                    n_state       = S_EMIT;
                end
            end
            S_FETCH: begin
                ram_rd_en   = 1'b1;
                ram_rd_addr = r_ptr;
                n_state     = S_TAKE;
            end
            S_TAKE: begin
                n_pend_value  = rd_data;
                n_pend_status = ST_DONE;
                if (ptr_p1 < r_count) begin
                    ram_rd_en   = 1'b1;
                    ram_rd_addr = r_ptr + t_addr'(1);
                    n_state     = S_SHIFT;
                end else begin
                    n_count = cnt_m1;
                    n_state = S_EMIT;
                end
            end
            S_SHIFT: begin
                // Entry r_ptr + 1 has arrived and moves down one place.
                ram_wr_en   = 1'b1;
                ram_wr_addr = r_ptr;
                ram_wr_data = rd_data;
                if (ptr_p1 < cnt_m1) begin
                    ram_rd_en   = 1'b1;
                    ram_rd_addr = r_ptr + t_addr'(2);
                    n_ptr       = r_ptr + t_addr'(1);
                end else begin
                    n_count = cnt_m1;
                    n_state = S_EMIT;
                end
            end
            S_LIST: begin
                if (slot_free) begin
                    n_out_valid  = 1'b1;
                    n_out_status = ST_DONE;
                    n_out_value  = rd_data;
                    n_out_last   = (ptr_p1 == r_count);
                    if (ptr_p1 == r_count) begin
                        n_state = S_IDLE;
                    end else begin
                        ram_rd_en   = 1'b1;
                        ram_rd_addr = r_ptr + t_addr'(1);
                        n_ptr       = r_ptr + t_addr'(1);
                    end
                end
            end
            S_EMIT: begin
                if (slot_free) begin
                    n_out_valid  = 1'b1;
                    n_out_status = r_pend_status;
                    n_out_value  = r_pend_value;
                    n_out_last   = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_out_valid <= n_out_valid;
        end
        r_ptr         <= n_ptr;
        r_action      <= n_action;
        r_key         <= n_key;
        r_pend_status <= n_pend_status;
        r_pend_value  <= n_pend_value;
        r_out_status  <= n_out_status;
        r_out_value   <= n_out_value;
        r_out_last    <= n_out_last;
    end

    assign i_in.ready         = (r_state == S_IDLE);
    assign o_out.valid        = r_out_valid;
    assign o_out.status       = r_out_status;
    assign o_out.result_value = r_out_value;
    assign o_out.last         = r_out_last;

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_FULL)
        else $error("entry count above list depth");

    a_count_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(i_rst_n) |-> (r_count == $past(r_count)) ||
                           (r_count == $past(r_count) + t_cnt'(1)) ||
                           (r_count == $past(r_count) - t_cnt'(1)))
        else $error("entry count moved by more than one");

    a_search_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SEARCH || r_state == S_LIST) |-> (t_cnt'(r_ptr) < r_count))
        else $error("read pointer beyond the stored entries");

    a_no_write_on_read_walk: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SEARCH || r_state == S_LIST || r_state == S_EMIT) |-> !ram_wr_en)
        else $error("store written during a read-only walk");

endmodule

// File: hw/rtl/bole_ram.sv
// Generic simple dual-port RAM with one write port and a registered read port.
module bole_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic                     i_rd_en,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule
